// ===== rtl/swne_pkg.sv =====
// ----------------------------------------------------------------------------
// swne_pkg
// Shared constants, types and register codes of the sliding window
// neighbourhood extractor.
// ----------------------------------------------------------------------------
package swne_pkg;

    localparam int LABEL_BITS = 16;
    localparam int MAX_RADIUS = 3;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_LIMIT  = 1024;

    localparam int SLOTS     = 2 * MAX_RADIUS + 1;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int ADDR_BITS = $clog2(MAX_HEIGHT);

    localparam int ROW_BITS = 10;
    localparam int COL_BITS = 10;
    localparam int TAP_BITS = 6;
    localparam int RAD_BITS = 2;
    localparam int DIM_BITS = 11;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    typedef struct packed {
        logic   en;
        slot_t  slot;
        addr_t  addr;
        label_t data;
    } wr_req_t;

    typedef struct packed {
        logic  en;
        slot_t slot;
        addr_t addr;
    } rd_req_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/swne_ram.sv =====
// ----------------------------------------------------------------------------
// swne_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module swne_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/swne_cell.sv =====
// ----------------------------------------------------------------------------
// swne_cell
// One column slot of the store. Writes and reads its own slot and passes
// the tap bus on to its neighbor, driving it when its slot is selected.
// ----------------------------------------------------------------------------
module swne_cell
    import swne_pkg::*;
(
    input  logic    aclk,
    input  slot_t   cell_id,
    input  wr_req_t wr,
    input  rd_req_t rd,
    input  slot_t   sel,
    input  label_t  chain_in,
    output label_t  chain_out
);

    label_t q;

    swne_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (MAX_HEIGHT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr.en && (wr.slot == cell_id)),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en && (rd.slot == cell_id)),
        .raddr (rd.addr),
        .rdata (q)
    );

    assign chain_out = (sel == cell_id) ? q : chain_in;

endmodule

// ===== rtl/sliding_window_neighbourhood_extract.sv =====
// ----------------------------------------------------------------------------
// sliding_window_neighbourhood_extract
// Column-store window extractor: column-major label pixels in, one item per
// window tap out.
// ----------------------------------------------------------------------------
// A pixel item that completes no interior window is taken whenever no tap
// read is pending. A pixel that completes a window of side s = 2*radius+1 is
// taken, then its s*s taps are read from the column store at one per cycle
// while the result side does not stall, and the next pixel is accepted only
// once the last tap read has passed to the output register. The rate is set
// by the single read port of the column cells, one tap read per cycle. The
// store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module sliding_window_neighbourhood_extract
    import swne_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LABEL_BITS-1:0] s_label_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_tap_value,
    output logic [TAP_BITS-1:0]   m_tap_index,
    output logic [ROW_BITS-1:0]   m_centre_row,
    output logic [COL_BITS-1:0]   m_centre_col,
    output logic                  m_last_tap
);

    logic [RAD_BITS-1:0] radius_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic [DIM_BITS-1:0] width_reg;

    logic [ROW_BITS-1:0] scan_row_reg, scan_row_next;
    logic [COL_BITS-1:0] scan_col_reg, scan_col_next;
    slot_t               scan_slot_reg, scan_slot_next;

    state_t state_reg, state_next;

    logic [ROW_BITS-1:0] centre_row_reg;
    logic [COL_BITS-1:0] centre_col_reg;
    logic [ROW_BITS-1:0] start_row_reg;
    logic [ROW_BITS-1:0] cur_row_reg;
    slot_t               cur_slot_reg;
    logic [RAD_BITS:0]   u_reg, v_reg, diam_reg;
    logic [TAP_BITS-1:0] tap_reg;

    logic                rd_pend_reg, rd_pend_next;
    slot_t               rd_slot_reg;
    logic [TAP_BITS-1:0] rd_idx_reg;
    logic                rd_last_reg;

    logic                  m_valid_reg, m_valid_next;
    label_t                tap_value_reg;
    logic [TAP_BITS-1:0]   tap_index_reg;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic                  last_tap_reg;

    logic                cfg_wr;
    logic [RAD_BITS-1:0] r_eff;
    logic [RAD_BITS:0]   diam;
    logic [DIM_BITS-1:0] h_eff, w_eff;
    logic [DIM_BITS-1:0] row_ext, col_ext, row_inc, col_inc;
    logic                accept, emit_hit, emitting;
    logic                issue, out_load, last_issue;
    logic [SLOT_BITS:0]  slot_sum;
    slot_t               start_slot;
    wr_req_t             wr;
    rd_req_t             rd;
    label_t              chain [SLOTS+1];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RAD_BITS'(1);
            height_reg <= DIM_BITS'(1024);
            width_reg  <= DIM_BITS'(1024);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[RAD_BITS-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = 32'(radius_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective sizes
    assign r_eff = (radius_reg > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius_reg;
    assign diam  = {r_eff, 1'b0};
    assign h_eff = (height_reg == '0) ? DIM_BITS'(1) :
                   (height_reg > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_reg;
    assign w_eff = (width_reg == '0) ? DIM_BITS'(1) :
                   (width_reg > DIM_BITS'(COL_LIMIT)) ? DIM_BITS'(COL_LIMIT) : width_reg;

    assign row_ext = DIM_BITS'(scan_row_reg);
    assign col_ext = DIM_BITS'(scan_col_reg);
    assign row_inc = row_ext + DIM_BITS'(1);
    assign col_inc = col_ext + DIM_BITS'(1);

    assign emit_hit = (row_ext < h_eff) && (col_ext < w_eff)
                   && (scan_row_reg >= ROW_BITS'(diam))
                   && (scan_col_reg >= COL_BITS'(diam));

    assign slot_sum   = (SLOT_BITS+1)'(scan_slot_reg) + (SLOT_BITS+1)'(SLOTS)
                      - (SLOT_BITS+1)'(diam);
    assign start_slot = (slot_sum >= (SLOT_BITS+1)'(SLOTS))
                      ? SLOT_BITS'(slot_sum - (SLOT_BITS+1)'(SLOTS))
                      : SLOT_BITS'(slot_sum);

    // Scan position
    always_comb begin
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        scan_slot_next = scan_slot_reg;
        if (accept) begin
            if (row_inc >= h_eff) begin
                scan_row_next = '0;
                if (col_inc >= w_eff) begin
                    scan_col_next  = '0;
                    scan_slot_next = '0;
                end else begin
                    scan_col_next  = COL_BITS'(col_inc);
                    scan_slot_next = (scan_slot_reg == SLOT_BITS'(SLOTS-1))
                                   ? '0 : scan_slot_reg + SLOT_BITS'(1);
                end
            end else begin
                scan_row_next = ROW_BITS'(row_inc);
                if (col_ext >= w_eff) begin
                    scan_col_next  = '0;
                    scan_slot_next = '0;
                end
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && emit_hit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue && last_issue) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_IDLE: begin
                s_ready  = !rd_pend_reg;
                emitting = 1'b0;
            end
            ST_EMIT: begin
                s_ready  = 1'b0;
                emitting = 1'b1;
            end
            default: begin
                s_ready  = 1'b0;
                emitting = 1'b0;
            end
        endcase
    end

    assign accept     = s_valid && s_ready;
    assign out_load   = rd_pend_reg && (!m_valid_reg || m_ready);
    assign issue      = emitting && (!rd_pend_reg || out_load);
    assign last_issue = (u_reg == diam_reg) && (v_reg == diam_reg);

    assign rd_pend_next = issue ? 1'b1 : (out_load ? 1'b0 : rd_pend_reg);
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            scan_slot_reg <= '0;
            rd_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            scan_slot_reg <= scan_slot_next;
            rd_pend_reg   <= rd_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Window walk: column outer, row inner
    always_ff @(posedge aclk) begin
        if (accept && emit_hit) begin
            centre_row_reg <= scan_row_reg - ROW_BITS'(r_eff);
            centre_col_reg <= scan_col_reg - COL_BITS'(r_eff);
            start_row_reg  <= scan_row_reg - ROW_BITS'(diam);
            cur_row_reg    <= scan_row_reg - ROW_BITS'(diam);
            cur_slot_reg   <= start_slot;
            u_reg          <= '0;
            v_reg          <= '0;
            diam_reg       <= diam;
            tap_reg        <= '0;
        end else if (issue) begin
            tap_reg <= tap_reg + TAP_BITS'(1);
            if (v_reg == diam_reg) begin
                v_reg        <= '0;
                u_reg        <= u_reg + (RAD_BITS+1)'(1);
                cur_row_reg  <= start_row_reg;
                cur_slot_reg <= (cur_slot_reg == SLOT_BITS'(SLOTS-1))
                              ? '0 : cur_slot_reg + SLOT_BITS'(1);
            end else begin
                v_reg       <= v_reg + (RAD_BITS+1)'(1);
                cur_row_reg <= cur_row_reg + ROW_BITS'(1);
            end
        end
        if (issue) begin
            rd_slot_reg <= cur_slot_reg;
            rd_idx_reg  <= tap_reg;
            rd_last_reg <= last_issue;
        end
        if (out_load) begin
            tap_value_reg <= chain[SLOTS];
            tap_index_reg <= rd_idx_reg;
            out_row_reg   <= centre_row_reg;
            out_col_reg   <= centre_col_reg;
            last_tap_reg  <= rd_last_reg;
        end
    end

    // Column cells
    assign wr.en   = accept;
    assign wr.slot = scan_slot_reg;
    assign wr.addr = ADDR_BITS'(scan_row_reg);
    assign wr.data = s_label_value;

    assign rd.en   = issue;
    assign rd.slot = cur_slot_reg;
    assign rd.addr = ADDR_BITS'(cur_row_reg);

    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        swne_cell u_cell (
            .aclk      (aclk),
            .cell_id   (SLOT_BITS'(g)),
            .wr        (wr),
            .rd        (rd),
            .sel       (rd_slot_reg),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    assign m_valid      = m_valid_reg;
    assign m_tap_value  = 16'(tap_value_reg);
    assign m_tap_index  = tap_index_reg;
    assign m_centre_row = out_row_reg;
    assign m_centre_col = out_col_reg;
    assign m_last_tap   = last_tap_reg;

endmodule

// ===== dv/sliding_window_neighbourhood_extract_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_neighbourhood_extract_test
// Self-checking bench for the window extractor. Label images are streamed in
// column-major order under many register settings. A scoreboard class keeps
// its own column store and scan position, predicts every window tap, and
// compares each tap against the oldest prediction. Both streams stall at
// random, and registers are only rewritten while no item is in flight.
// ----------------------------------------------------------------------------
module sliding_window_neighbourhood_extract_test;
    import swne_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0]         tap_value;
        logic [TAP_BITS-1:0] tap_index;
        logic [ROW_BITS-1:0] centre_row;
        logic [COL_BITS-1:0] centre_col;
        logic                last_tap;
    } tap_t;

    class window_tap_board;
        logic [15:0] labels_kept [SLOTS*MAX_HEIGHT];
        int unsigned row_at;
        int unsigned col_at;
        logic [RAD_BITS-1:0] radius_reg;
        logic [DIM_BITS-1:0] height_reg;
        logic [DIM_BITS-1:0] width_reg;
        tap_t taps_due [$];
        int errors;
        int windows;
        int taps_checked;

        function void reset_state();
            foreach (labels_kept[k]) labels_kept[k] = '0;
            row_at = 0;
            col_at = 0;
            radius_reg = RAD_BITS'(1);
            height_reg = DIM_BITS'(1024);
            width_reg = DIM_BITS'(1024);
        endfunction

        function int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_RADIUS: radius_reg = value[RAD_BITS-1:0];
                REG_HEIGHT: height_reg = value[DIM_BITS-1:0];
                REG_WIDTH:  width_reg  = value[DIM_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(height_reg, MAX_HEIGHT) * clamp_dim(width_reg, COL_LIMIT);
        endfunction

        function void note_pixel(logic [15:0] px);
            int unsigned r, h, w, side, ci, cj, n;
            tap_t t;
            r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
            h = clamp_dim(height_reg, MAX_HEIGHT);
            w = clamp_dim(width_reg, COL_LIMIT);
            side = 2 * r + 1;
            labels_kept[(col_at % SLOTS) * MAX_HEIGHT + (row_at % MAX_HEIGHT)] = px;
            if (row_at < h && col_at < w && row_at >= 2 * r && col_at >= 2 * r) begin
                ci = row_at - r;
                cj = col_at - r;
                n = 0;
                for (int unsigned u = 0; u < side; u++) begin
                    for (int unsigned v = 0; v < side; v++) begin
                        t.tap_value  = labels_kept[((cj - r + u) % SLOTS) * MAX_HEIGHT
                                                   + ((ci - r + v) % MAX_HEIGHT)];
                        t.tap_index  = n[TAP_BITS-1:0];
                        t.centre_row = ci[ROW_BITS-1:0];
                        t.centre_col = cj[COL_BITS-1:0];
                        t.last_tap   = (n + 1 == side * side);
                        taps_due.push_back(t);
                        n++;
                    end
                end
                windows++;
            end
            row_at++;
            if (row_at >= h) begin
                row_at = 0;
                col_at++;
                if (col_at >= w) col_at = 0;
            end else if (col_at >= w) begin
                col_at = 0;
            end
        endfunction

        function void check_tap(tap_t got);
            tap_t want;
            if (taps_due.size() == 0) begin
                $error("unexpected tap: value %0h index %0d centre (%0d,%0d)",
                       got.tap_value, got.tap_index, got.centre_row, got.centre_col);
                errors++;
                return;
            end
            want = taps_due.pop_front();
            taps_checked++;
            if (got.tap_value !== want.tap_value) begin
                $error("tap_value: expected %0h, got %0h", want.tap_value, got.tap_value);
                errors++;
            end
            if (got.tap_index !== want.tap_index) begin
                $error("tap_index: expected %0d, got %0d", want.tap_index, got.tap_index);
                errors++;
            end
            if (got.centre_row !== want.centre_row) begin
                $error("centre_row: expected %0d, got %0d", want.centre_row, got.centre_row);
                errors++;
            end
            if (got.centre_col !== want.centre_col) begin
                $error("centre_col: expected %0d, got %0d", want.centre_col, got.centre_col);
                errors++;
            end
            if (got.last_tap !== want.last_tap) begin
                $error("last_tap: expected %0b, got %0b", want.last_tap, got.last_tap);
                errors++;
            end
        endfunction

        function int pending();
            return taps_due.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [LABEL_BITS-1:0] s_label_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [15:0]           m_tap_value;
    logic [TAP_BITS-1:0]   m_tap_index;
    logic [ROW_BITS-1:0]   m_centre_row;
    logic [COL_BITS-1:0]   m_centre_col;
    logic                  m_last_tap;

    window_tap_board board = new();
    int  pixel_count;
    int  settings_used;
    bit  s_calm;
    bit  m_calm;

    sliding_window_neighbourhood_extract DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_label_value (s_label_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tap_value   (m_tap_value),
        .m_tap_index   (m_tap_index),
        .m_centre_row  (m_centre_row),
        .m_centre_col  (m_centre_col),
        .m_last_tap    (m_last_tap)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        int p;
        if (calm) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_label();
        int p;
        p = $urandom_range(0, 15);
        if (p == 0) return 16'h0000;
        if (p == 1) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // result side: check every accepted tap, stall at random
    initial begin
        tap_t got;
        int   stall_left;
        int   cyc;
        stall_left = 0;
        cyc = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.tap_value  = m_tap_value;
                got.tap_index  = m_tap_index;
                got.centre_row = m_centre_row;
                got.centre_col = m_centre_col;
                got.last_tap   = m_last_tap;
                board.check_tap(got);
            end
            if (cyc % 256 == 0) m_calm = ($urandom_range(0, 3) == 0);
            cyc++;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap(m_calm);
                if (stall_left == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    stall_left--;
                end
            end
        end
    end

    task automatic send_pixel(input logic [15:0] v);
        int gap;
        gap = pick_gap(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_label_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pixel(v);
        pixel_count++;
    endtask

    // let every predicted tap arrive, then allow for a pixel still in flight
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic apply_setting(input int r, input int h, input int w);
        drain();
        apb_write(REG_RADIUS, r);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_WIDTH, w);
        settings_used++;
    endtask

    task automatic send_frames(input int frames);
        repeat (frames * board.frame_pixels()) begin
            if ($urandom_range(0, 99) == 0) drain();
            send_pixel(pick_label());
        end
    endtask

    initial begin
        logic [15:0] pat3 [9];
        logic [15:0] pat2 [4];
        int r, h, w;
        int random_items;
        int start_count;
        pat3 = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hAAAA,
                 16'h5555, 16'h7FFF, 16'hFFFE, 16'h1234};
        pat2 = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};
        board.reset_state();
        s_calm = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: smallest radius-1 window, radius 0, zero sizes
        apply_setting(1, 3, 3);
        foreach (pat3[k]) send_pixel(pat3[k]);
        apply_setting(0, 2, 2);
        foreach (pat2[k]) send_pixel(pat2[k]);
        apply_setting(0, 0, 0);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);

        // height shrunk mid-column: scan row left outside the new height
        apply_setting(0, 4, 2);
        repeat (3) send_pixel(pick_label());
        drain();
        apb_write(REG_HEIGHT, 2);
        repeat (3) send_pixel(pick_label());

        // random small images, whole frames per setting
        random_items = 0;
        while (random_items < 220) begin
            r = $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0) h = $urandom_range(1, 12);
            else h = $urandom_range(2 * r + 1, 2 * r + 6);
            if ($urandom_range(0, 4) == 0) w = $urandom_range(1, 12);
            else w = $urandom_range(2 * r + 1, 2 * r + 6);
            apply_setting(r, h, w);
            s_calm = ($urandom_range(0, 3) == 0);
            start_count = pixel_count;
            send_frames(1);
            random_items += pixel_count - start_count;
        end

        // out-of-range register values, partial frames to close the run
        s_calm = 1'b0;
        apply_setting(1, 3, 2047);
        repeat (36) send_pixel(pick_label());
        apply_setting(0, 2047, 1);
        repeat (24) send_pixel(pick_label());

        drain();
        repeat (20) @(posedge aclk);
        $display("tb: %0d pixel items streamed under %0d register settings, radius 0 to 3",
                 pixel_count, settings_used);
        $display("tb: %0d windows predicted, %0d taps compared",
                 board.windows, board.taps_checked);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
